// File: hw/rtl/pca_pkg.sv
// Shared widths, codes and saturation helpers for the PID controller with anti-windup.
package pca_pkg;

    localparam int VW       = 32;           // value width
    localparam int FB       = 16;           // value fraction bits
    localparam int TF       = 16;           // time step fraction bits
    localparam int DTW      = 16;           // time step width
    localparam int TAUW     = 24;           // filter time constant width
    localparam int INTEG_W  = 48;           // integrator width
    localparam int MA_W     = INTEG_W;      // multiplicand width
    localparam int MB_W     = VW;           // multiplier width
    localparam int MP_W     = MA_W + MB_W + 1;
    localparam int DN_W     = 58;           // signed dividend width
    localparam int DD_W     = TAUW + 1;     // divisor width
    localparam int DQ_W     = DN_W + 1;     // signed quotient width
    localparam int SUM_W    = 67;           // weighted sum width
    localparam int WIDE_W   = MP_W;         // width for saturation checks
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_GAIN_PROP  = 3'd1,
        CFG_GAIN_INTEG = 3'd2,
        CFG_GAIN_DERIV = 3'd3,
        CFG_INTEG_LIM  = 3'd4,
        CFG_DRIVE_LIM  = 3'd5,
        CFG_FILTER_TAU = 3'd6
    } t_cfg_idx;

    localparam logic [1:0] MODE_TRACK  = 2'd0;
    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CLAMP_LOW  = 2'd2;

    function automatic logic signed [VW-1:0] f_sat_val(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] mx;
        logic signed [WIDE_W-1:0] mn;
        mx = {{(WIDE_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
        mn = ~mx;
        if (x > mx) return mx[VW-1:0];
        else if (x < mn) return mn[VW-1:0];
        else return x[VW-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] f_sat_int(
        input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] mx;
        logic signed [WIDE_W-1:0] mn;
        mx = {{(WIDE_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
        mn = ~mx;
        if (x > mx) return mx[INTEG_W-1:0];
        else if (x < mn) return mn[INTEG_W-1:0];
        else return x[INTEG_W-1:0];
    endfunction

endpackage

// File: hw/rtl/pca_if.sv
// Handshake channel interfaces: control step input, result output, register write.
interface pca_in_if;
    import pca_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic signed [VW-1:0]  setpoint;
    logic signed [VW-1:0]  measurement;
    logic signed [VW-1:0]  direct_error;
    logic signed [VW-1:0]  measured_rate;
    logic [DTW-1:0]        time_step;
    modport source (output valid, mode, setpoint, measurement, direct_error,
                    measured_rate, time_step, input ready);
    modport sink   (input valid, mode, setpoint, measurement, direct_error,
                    measured_rate, time_step, output ready);
endinterface

interface pca_out_if;
    import pca_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [VW-1:0]  drive;
    logic [1:0]            clamp_state;
    modport source (output valid, drive, clamp_state, input ready);
    modport sink   (input valid, drive, clamp_state, output ready);
endinterface

interface pca_cfg_if;
    import pca_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [VW-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/pid_controller_antiwindup.sv
// PID controller with setpoint filter, clamps and integral anti-windup (top level).
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  i_cfg    | in  | index, data: one register write, always ready
//  i_in     | in  | mode, setpoint, measurement, direct_error, measured_rate,
//           |     | time_step: one control step
//  o_out    | out | drive, clamp_state: one result per step
//
// One step at a time. The shared shift-add multiplier and the shared restoring divider
// set the length: a filtered mode 0 step adds two products and a quotient to a mode 1
// step, and a disabled, clear or unused-mode step goes straight to the output register.
// Synchronous active-low reset clears state and registers with enable set. A finished
// result waits in the output register while the next step is taken; a step stalls at
// its end only while a result is held.
module pid_controller_antiwindup
    import pca_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pca_cfg_if.sink      i_cfg,
    pca_in_if.sink       i_in,
    pca_out_if.source    o_out
);
    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_FM1  = 20'h00002,
        S_FW1  = 20'h00004,
        S_FM2  = 20'h00008,
        S_FW2  = 20'h00010,
        S_FDV  = 20'h00020,
        S_FDW  = 20'h00040,
        S_ERR  = 20'h00080,
        S_IM   = 20'h00100,
        S_IW   = 20'h00200,
        S_DDV  = 20'h00400,
        S_DDW  = 20'h00800,
        S_PM   = 20'h01000,
        S_PW   = 20'h02000,
        S_GIM  = 20'h04000,
        S_GIW  = 20'h08000,
        S_GDM  = 20'h10000,
        S_GDW  = 20'h20000,
        S_FIN  = 20'h40000,
        S_OUT  = 20'h80000
    } t_state;

    t_state r_state;

    // configuration
    logic                       r_enable;
    logic signed [VW-1:0]       r_gp, r_gi, r_gd;
    logic [VW-2:0]              r_ilim, r_dlim;
    logic [TAUW-1:0]            r_tau;

    // controller state
    logic signed [VW-1:0]       r_ft;
    logic                       r_seen;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [VW-1:0]       r_perr;
    logic signed [VW-1:0]       r_prate;
    logic                       r_hv;

    // step working registers
    logic [1:0]                 r_mode;
    logic signed [VW-1:0]       r_sp, r_meas, r_derr, r_rate;
    logic [DTW-1:0]             r_dt;
    logic signed [MA_W-1:0]     r_p1;
    logic signed [DN_W-1:0]     r_num;
    logic signed [VW-1:0]       r_err, r_step, r_deriv;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [VW-1:0]       r_drive;
    logic [1:0]                 r_clamp;

    // output register
    logic                       r_o_valid;
    logic signed [VW-1:0]       r_o_drive;
    logic [1:0]                 r_o_clamp;

    logic                       w_mul_start, w_mul_done;
    logic signed [MA_W-1:0]     w_ma;
    logic signed [MB_W-1:0]     w_mb;
    logic signed [MP_W-1:0]     w_prod;
    logic                       w_div_start, w_div_done;
    logic signed [DN_W-1:0]     w_dnum;
    logic [DD_W-1:0]            w_dden;
    logic signed [DQ_W-1:0]     w_quot;

    logic                       w_accept;
    logic signed [VW:0]         w_tdiff, w_ediff;
    logic signed [VW-1:0]       w_step;
    logic signed [INTEG_W:0]    w_isum;
    logic signed [INTEG_W-1:0]  w_isat, w_ilim, w_inew;
    logic signed [INTEG_W-1:0]  w_iback;
    logic signed [VW-1:0]       w_dsat, w_dlim, w_dnew;
    logic [1:0]                 w_cnew;
    logic signed [SUM_W-1:0]    w_term;
    logic                       w_use_deriv;

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign w_use_deriv = (r_dt != '0) && r_hv;

    assign w_mul_start = (r_state == S_FM1) || (r_state == S_FM2) || (r_state == S_IM) ||
                         (r_state == S_PM) || (r_state == S_GIM) || (r_state == S_GDM);
    assign w_div_start = (r_state == S_FDV) || ((r_state == S_DDV) && w_use_deriv);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_FM1: begin w_ma = MA_W'(r_sp);    w_mb = MB_W'($signed({1'b0, r_dt}));  end
            S_FM2: begin w_ma = MA_W'(r_ft);    w_mb = MB_W'($signed({1'b0, r_tau})); end
            S_IM:  begin w_ma = MA_W'(r_err);   w_mb = MB_W'($signed({1'b0, r_dt}));  end
            S_PM:  begin w_ma = MA_W'(r_err);   w_mb = r_gp; end
            S_GIM: begin w_ma = r_integ;        w_mb = r_gi; end
            S_GDM: begin w_ma = MA_W'(r_deriv); w_mb = r_gd; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_ediff = (VW+1)'(r_err) - (VW+1)'(r_perr);
    assign w_tdiff = (VW+1)'(r_ft) - (VW+1)'(r_meas);
    assign w_dnum  = (r_state == S_FDV) ? r_num : (DN_W'(w_ediff) <<< TF);
    assign w_dden  = (r_state == S_FDV) ? (DD_W'(r_dt) + DD_W'(r_tau)) : DD_W'(r_dt);

    // integral step, accumulate and clamp
    always_comb begin
        w_step = $signed(w_prod[TF+VW-1:TF]);
        w_isum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(w_step);
        w_isat = f_sat_int(WIDE_W'(w_isum));
        w_ilim = INTEG_W'({1'b0, r_ilim});
        w_inew = w_isat;
        if (r_ilim != '0) begin
            if (w_isat > w_ilim) w_inew = w_ilim;
            if (w_isat < -w_ilim) w_inew = -w_ilim;
        end
    end

    // output clamp
    always_comb begin
        w_term = SUM_W'(w_prod >>> FB);
        w_dsat = f_sat_val(WIDE_W'(r_sum));
        w_dlim = VW'({1'b0, r_dlim});
        w_dnew = w_dsat;
        w_cnew = CLAMP_NONE;
        if (r_dlim != '0) begin
            if (w_dsat > w_dlim) begin
                w_dnew = w_dlim;
                w_cnew = CLAMP_HIGH;
            end
            if (w_dsat < -w_dlim) begin
                w_dnew = -w_dlim;
                w_cnew = CLAMP_LOW;
            end
        end
        w_iback = f_sat_int(WIDE_W'(r_integ) - WIDE_W'(r_step));
    end

    pca_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_gp     <= '0;
            r_gi     <= '0;
            r_gd     <= '0;
            r_ilim   <= '0;
            r_dlim   <= '0;
            r_tau    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ENABLE:     r_enable <= i_cfg.data[0];
                CFG_GAIN_PROP:  r_gp     <= $signed(i_cfg.data);
                CFG_GAIN_INTEG: r_gi     <= $signed(i_cfg.data);
                CFG_GAIN_DERIV: r_gd     <= $signed(i_cfg.data);
                CFG_INTEG_LIM:  r_ilim   <= i_cfg.data[VW-2:0];
                CFG_DRIVE_LIM:  r_dlim   <= i_cfg.data[VW-2:0];
                CFG_FILTER_TAU: r_tau    <= i_cfg.data[TAUW-1:0];
                default: ;
            endcase
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ft      <= '0;
            r_seen    <= 1'b0;
            r_integ   <= '0;
            r_perr    <= '0;
            r_prate   <= '0;
            r_hv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_o_valid || o_out.ready)) r_o_valid <= 1'b1;
            else if (o_out.ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode  <= i_in.mode;
                        r_sp    <= i_in.setpoint;
                        r_meas  <= i_in.measurement;
                        r_derr  <= i_in.direct_error;
                        r_rate  <= i_in.measured_rate;
                        r_dt    <= i_in.time_step;
                        r_drive <= '0;
                        r_clamp <= CLAMP_NONE;
                        if (!r_enable || (i_in.mode != MODE_TRACK &&
                                          i_in.mode != MODE_DIRECT &&
                                          i_in.mode != MODE_CLEAR)) begin
                            r_state <= S_OUT;
                        end else if (i_in.mode == MODE_CLEAR) begin
                            r_ft    <= '0;
                            r_seen  <= 1'b0;
                            r_integ <= '0;
                            r_perr  <= '0;
                            r_prate <= '0;
                            r_hv    <= 1'b0;
                            r_state <= S_OUT;
                        end else if (i_in.mode == MODE_TRACK) begin
                            if (!r_seen) begin
                                r_ft   <= i_in.setpoint;
                                r_seen <= 1'b1;
                            end
                            // a zero denominator leaves the filter alone
                            if (i_in.time_step != '0 || r_tau != '0) r_state <= S_FM1;
                            else r_state <= S_ERR;
                        end else begin
                            r_state <= S_ERR;
                        end
                    end
                end
                S_FM1: r_state <= S_FW1;
                S_FW1: begin
                    if (w_mul_done) begin
                        r_p1    <= MA_W'(w_prod);
                        r_state <= S_FM2;
                    end
                end
                S_FM2: r_state <= S_FW2;
                S_FW2: begin
                    if (w_mul_done) begin
                        r_num   <= DN_W'(r_p1) + DN_W'(w_prod);
                        r_state <= S_FDV;
                    end
                end
                S_FDV: r_state <= S_FDW;
                S_FDW: begin
                    if (w_div_done) begin
                        r_ft    <= f_sat_val(WIDE_W'(w_quot));
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= (r_mode == MODE_TRACK) ? f_sat_val(WIDE_W'(w_tdiff)) : r_derr;
                    r_state <= S_IM;
                end
                S_IM: r_state <= S_IW;
                S_IW: begin
                    if (w_mul_done) begin
                        r_step  <= w_step;
                        r_integ <= w_inew;
                        r_state <= S_DDV;
                    end
                end
                S_DDV: begin
                    if (w_use_deriv) begin
                        r_state <= S_DDW;
                    end else begin
                        r_deriv <= f_sat_val(-WIDE_W'(r_rate));
                        r_state <= S_PM;
                    end
                end
                S_DDW: begin
                    if (w_div_done) begin
                        r_deriv <= f_sat_val(WIDE_W'(w_quot) + WIDE_W'(r_prate) -
                                             WIDE_W'(r_rate));
                        r_state <= S_PM;
                    end
                end
                S_PM: begin
                    r_prate <= r_rate;
                    r_perr  <= r_err;
                    r_hv    <= 1'b1;
                    r_state <= S_PW;
                end
                S_PW: begin
                    if (w_mul_done) begin
                        r_sum   <= w_term;
                        r_state <= S_GIM;
                    end
                end
                S_GIM: r_state <= S_GIW;
                S_GIW: begin
                    if (w_mul_done) begin
                        r_sum   <= r_sum + w_term;
                        r_state <= S_GDM;
                    end
                end
                S_GDM: r_state <= S_GDW;
                S_GDW: begin
                    if (w_mul_done) begin
                        r_sum   <= r_sum + w_term;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_drive <= w_dnew;
                    r_clamp <= w_cnew;
                    // undo the integral step when the clamp pushes with the error
                    if (r_dt != '0 &&
                        ((w_cnew == CLAMP_HIGH && r_err > 0) ||
                         (w_cnew == CLAMP_LOW && r_err < 0))) begin
                        r_integ <= w_iback;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_drive <= r_drive;
                        r_o_clamp <= r_clamp;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.drive       = r_o_drive;
    assign o_out.clamp_state = r_o_clamp;
endmodule

// File: hw/rtl/pca_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle.
module pca_mul
    import pca_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [MA_W-1:0]  i_a,
    input  logic signed [MB_W-1:0]  i_b,
    output logic                    o_done,
    output logic signed [MP_W-1:0]  o_prod
);
    localparam int CNT_W = $clog2(MB_W + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_neg;
    logic [MA_W-1:0]         r_mcand;
    logic [MB_W-1:0]         r_mpl;
    logic [MA_W+MB_W-1:0]    r_acc;
    logic signed [MP_W-1:0]  r_prod;

    logic [MA_W-1:0]         w_amag;
    logic [MB_W-1:0]         w_bmag;
    logic [MA_W:0]           w_hi;
    logic signed [MP_W-1:0]  w_mag;

    assign w_amag = i_a[MA_W-1] ? MA_W'(-i_a) : MA_W'(i_a);
    assign w_bmag = i_b[MB_W-1] ? MB_W'(-i_b) : MB_W'(i_b);
    assign w_hi   = {1'b0, r_acc[MA_W+MB_W-1:MB_W]} + (r_mpl[0] ? {1'b0, r_mcand} : '0);
    assign w_mag  = {1'b0, r_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(MB_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg   <= i_a[MA_W-1] ^ i_b[MB_W-1];
            r_mcand <= w_amag;
            r_mpl   <= w_bmag;
            r_acc   <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(MB_W)) begin
                r_prod <= r_neg ? -w_mag : w_mag;
            end else begin
                // add into the top half, then shift the whole product right
                r_acc <= {w_hi, r_acc[MB_W-1:1]};
                r_mpl <= r_mpl >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

// File: hw/rtl/pca_div.sv
// Restoring signed divider, one quotient bit per cycle, quotient rounds toward zero.
module pca_div
    import pca_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DN_W-1:0]  i_num,
    input  logic [DD_W-1:0]         i_den,
    output logic                    o_done,
    output logic signed [DQ_W-1:0]  o_quot
);
    localparam int CNT_W = $clog2(DN_W + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_neg;
    logic [DN_W-1:0]         r_q;
    logic [DD_W-1:0]         r_rem;
    logic [DD_W-1:0]         r_den;
    logic signed [DQ_W-1:0]  r_quot;

    logic [DD_W+1:0]         w_trial;
    logic [DD_W:0]           w_shift;
    logic signed [DQ_W-1:0]  w_mag;

    assign w_shift = {r_rem, r_q[DN_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};
    assign w_mag   = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DN_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DN_W-1];
            r_q   <= i_num[DN_W-1] ? DN_W'(-i_num) : DN_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(DN_W)) begin
                r_quot <= r_neg ? -w_mag : w_mag;
            end else if (!w_trial[DD_W+1]) begin
                r_rem <= w_trial[DD_W-1:0];
                r_q   <= {r_q[DN_W-2:0], 1'b1};
            end else begin
                // keep the partial remainder, it stays below the divisor
                r_rem <= w_shift[DD_W-1:0];
                r_q   <= {r_q[DN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
